// ===== hw/rtl/pfe_pkg.sv =====
`timescale 1ns / 1ps
// pfe_pkg: shared types, constants and the Q.28 multiply for the phase function evaluator.
// Used by pfe_sqrt, pfe_div, phase_function_evaluator and tb_top; depends on nothing.
package pfe_pkg;

	// internal fixed point: signed, 28 fraction bits
	localparam int WB = 28;
	localparam int QW = 34;
	typedef logic signed [QW-1:0] q_t;

	localparam q_t ONE_Q        = 34'sd268435456;
	localparam q_t HALF_Q       = 34'sd134217728;
	localparam q_t INV4PI_Q     = 34'sd21361415;
	localparam q_t RAY_Q        = 34'sd16021061;
	localparam q_t K155_Q       = 34'sd416074957;
	localparam q_t K055_Q       = 34'sd147639501;
	localparam q_t MIE_HAZY_Q   = 34'sd1207959552;
	localparam q_t MIE_MURKY_Q  = 34'sd4429185024;

	// asymmetry register: Q1.14, limited to +-0.9
	localparam int G_W = 15;
	localparam int G_BITS = 14;
	localparam logic signed [G_W-1:0] G_LIMIT = 15'sd14746;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ASYM_G = 1'b1;

	typedef enum logic [2:0] {
		MODE_ISO     = 3'd0,
		MODE_RAY     = 3'd1,
		MODE_HAZY    = 3'd2,
		MODE_MURKY   = 3'd3,
		MODE_HG      = 3'd4,
		MODE_SCHLICK = 3'd5
	} mode_t;

	// square root unit: radicand Q.56, root Q.28
	localparam int SQ_IN_W = 58;
	localparam int SQ_ROOT_W = 29;
	localparam int SQ_REM_W = 32;

	// divider: dividend and quotient width, divisor width
	localparam int DIV_N_W = 54;
	localparam int DIV_D_W = 32;

	typedef struct packed {
		mode_t mode;
		logic  clamped;
		q_t    v_direct;
		q_t    num;
		q_t    d;
		q_t    sden;
	} sq_tag_t;

	typedef struct packed {
		logic use_div;
		logic fail;
		logic clamped;
		q_t   v_direct;
	} div_tag_t;

	// sign-magnitude product rounded to Q.28, ties away from zero
	function automatic q_t fmul(input q_t a, input q_t b);
		logic [QW-1:0] ma;
		logic [QW-1:0] mb;
		logic [2*QW-1:0] p;
		logic [2*QW-1:0] r;
		ma = a[QW-1] ? (~a + 1'b1) : a;
		mb = b[QW-1] ? (~b + 1'b1) : b;
		p = ma * mb;
		r = (p + (2*QW)'(HALF_Q)) >> WB;
		fmul = (a[QW-1] ^ b[QW-1]) ? -q_t'(r[QW-1:0]) : q_t'(r[QW-1:0]);
	endfunction

endpackage

// ===== hw/rtl/pfe_sqrt.sv =====
`timescale 1ns / 1ps
// pfe_sqrt: pipelined floor square root, one result bit per stage, with a side tag.
// Depends on pfe_pkg.
module pfe_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [pfe_pkg::SQ_IN_W-1:0]        in_rad,
	input  pfe_pkg::sq_tag_t                   in_tag,
	output logic                               out_valid,
	output logic [pfe_pkg::SQ_ROOT_W-1:0]      out_root,
	output pfe_pkg::sq_tag_t                   out_tag
);

	localparam int N = pfe_pkg::SQ_ROOT_W;
	localparam int RW = pfe_pkg::SQ_REM_W;
	localparam int IW = pfe_pkg::SQ_IN_W;

	logic [RW-1:0]          rem_s  [1:N];
	logic [N-1:0]           root_s [1:N];
	logic [IW-1:0]          rad_s  [1:N];
	pfe_pkg::sq_tag_t       tag_s  [1:N];
	logic [N:1]             vld_s;

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic [RW-1:0]    rem_p;
		logic [N-1:0]     root_p;
		logic [IW-1:0]    rad_p;
		pfe_pkg::sq_tag_t tag_p;
		logic             vld_p;
		logic [RW-1:0]    trial_rem;
		logic [RW-1:0]    trial;
		logic             ge;

		if (k == 1) begin : g_first
			assign rem_p = '0;
			assign root_p = '0;
			assign rad_p = in_rad;
			assign tag_p = in_tag;
			assign vld_p = in_valid;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p = rad_s[k-1];
			assign tag_p = tag_s[k-1];
			assign vld_p = vld_s[k-1];
		end

		// bring down two radicand bits, try (4*root + 1)
		always_comb begin
			trial_rem = {rem_p[RW-3:0], rad_p[IW-1:IW-2]};
			trial = RW'({root_p, 2'b01});
			ge = (trial_rem >= trial);
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? (trial_rem - trial) : trial_rem;
			root_s[k] <= {root_p[N-2:0], ge};
			rad_s[k] <= {rad_p[IW-3:0], 2'b00};
			tag_s[k] <= tag_p;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root = root_s[N];
	assign out_tag = tag_s[N];

endmodule

// ===== hw/rtl/pfe_div.sv =====
`timescale 1ns / 1ps
// pfe_div: pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on pfe_pkg.
module pfe_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [pfe_pkg::DIV_N_W-1:0]     in_dividend,
	input  logic [pfe_pkg::DIV_D_W-1:0]     in_divisor,
	input  pfe_pkg::div_tag_t               in_tag,
	output logic                            out_valid,
	output logic [pfe_pkg::DIV_N_W-1:0]     out_quot,
	output pfe_pkg::div_tag_t               out_tag
);

	localparam int N = pfe_pkg::DIV_N_W;
	localparam int D = pfe_pkg::DIV_D_W;

	logic [D-1:0]        rem_s [1:N];
	logic [N-1:0]        dq_s  [1:N];
	logic [D-1:0]        dvs_s [1:N];
	pfe_pkg::div_tag_t   tag_s [1:N];
	logic [N:1]          vld_s;

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic [D-1:0]      rem_p;
		logic [N-1:0]      dq_p;
		logic [D-1:0]      dvs_p;
		pfe_pkg::div_tag_t tag_p;
		logic              vld_p;
		logic [D:0]        trial;
		logic [D:0]        diff;
		logic              ge;

		if (k == 1) begin : g_first
			assign rem_p = '0;
			assign dq_p = in_dividend;
			assign dvs_p = in_divisor;
			assign tag_p = in_tag;
			assign vld_p = in_valid;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign dq_p = dq_s[k-1];
			assign dvs_p = dvs_s[k-1];
			assign tag_p = tag_s[k-1];
			assign vld_p = vld_s[k-1];
		end

		// shift in the next dividend bit and subtract the divisor if it fits
		always_comb begin
			trial = {rem_p, dq_p[N-1]};
			diff = trial - {1'b0, dvs_p};
			ge = (trial >= {1'b0, dvs_p});
		end

		// dividend bits leave at the top while quotient bits enter at the bottom
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[D-1:0] : trial[D-1:0];
			dq_s[k] <= {dq_p[N-2:0], ge};
			dvs_s[k] <= dvs_p;
			tag_s[k] <= tag_p;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_quot = dq_s[N];
	assign out_tag = tag_s[N];

endmodule

// ===== hw/rtl/phase_function_evaluator.sv =====
`timescale 1ns / 1ps
// phase_function_evaluator: top level, dot product, phase function pipeline and output rounding.
// Depends on pfe_pkg, pfe_sqrt and pfe_div.
//
// Usage:
//  - Input channel: a transaction is taken at a rising edge with start high and busy low.
//    busy never rises, so a new direction pair may be presented in every cycle.
//  - Result channel: done is high for one cycle with phase_value, cos_clamped and
//    value_saturated; the receiver cannot hold results off and none is needed.
//  - Pipeline: a result passes nine stages of dot product and Q.28 arithmetic,
//    29 square root stages (one root bit each), one stage for the Henyey-Greenstein
//    denominator, 54 divider stages (one quotient bit each) and the output register.
//    Throughput is one transaction per cycle in every mode.
//  - Configuration: phase_mode (index 0) and asymmetry_g (index 1) are written through
//    cfg_wr_en, cfg_index and cfg_wr_data while no transaction is in flight.
//  - Reset clears the valid bits and sets phase_mode to isotropic and asymmetry_g to 0.
module phase_function_evaluator #(
	parameter int FRAC_BITS_IN = 14,
	parameter int FRAC_BITS_OUT = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [15:0]                   out_dir_x,
	input  logic signed [15:0]                   out_dir_y,
	input  logic signed [15:0]                   out_dir_z,
	input  logic signed [15:0]                   in_dir_x,
	input  logic signed [15:0]                   in_dir_y,
	input  logic signed [15:0]                   in_dir_z,
	input  logic                                 cfg_wr_en,
	input  logic [pfe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pfe_pkg::G_W-1:0]              cfg_wr_data,
	output logic                                 done,
	output logic [23:0]                          phase_value,
	output logic                                 cos_clamped,
	output logic                                 value_saturated
);

	localparam int WB = pfe_pkg::WB;
	localparam int QW = pfe_pkg::QW;
	localparam int DW = (2 * FRAC_BITS_IN + 3 > 35) ? 2 * FRAC_BITS_IN + 3 : 35;
	localparam int SH_IN = 2 * FRAC_BITS_IN - WB;
	localparam int SHR = (SH_IN > 0) ? SH_IN : 0;
	localparam int SHL = (SH_IN < 0) ? -SH_IN : 0;
	localparam logic [DW-1:0] RND_IN = (DW'(1) << SHR) >> 1;
	localparam logic signed [DW-1:0] LIM = DW'(1) << (2 * FRAC_BITS_IN);
	localparam int VW = pfe_pkg::DIV_N_W + 1;
	localparam int OSH = WB - FRAC_BITS_OUT;
	localparam logic [VW-1:0] RND_OUT = (VW'(1) << OSH) >> 1;
	localparam logic [VW-1:0] OUT_MAX = VW'(24'hFFFFFF);

	typedef struct packed {
		pfe_pkg::mode_t mode;
		logic           clamped;
		pfe_pkg::q_t    g;
		pfe_pkg::q_t    c;
	} ctx_t;

	// configuration registers
	pfe_pkg::mode_t                     mode_q;
	logic signed [pfe_pkg::G_W-1:0]     g_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pfe_pkg::MODE_ISO;
			g_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pfe_pkg::REG_PHASE_MODE: mode_q <= pfe_pkg::mode_t'(cfg_wr_data[2:0]);
				pfe_pkg::REG_ASYM_G: g_q <= signed'(cfg_wr_data);
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid bits of the front stages
	logic [9:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[8:1], start & ~busy};
		end
	end

	// g limited to +-0.9 and moved to Q.28
	logic signed [pfe_pkg::G_W-1:0] gsat;
	always_comb begin
		gsat = g_q;
		if (g_q > pfe_pkg::G_LIMIT) gsat = pfe_pkg::G_LIMIT;
		if (g_q < -pfe_pkg::G_LIMIT) gsat = -pfe_pkg::G_LIMIT;
	end

	// S1: component products
	logic signed [31:0]  px_s1, py_s1, pz_s1;
	pfe_pkg::mode_t      mode_s1;
	pfe_pkg::q_t         g_s1;

	always_ff @(posedge clk) begin
		px_s1 <= out_dir_x * in_dir_x;
		py_s1 <= out_dir_y * in_dir_y;
		pz_s1 <= out_dir_z * in_dir_z;
		mode_s1 <= mode_q;
		g_s1 <= pfe_pkg::q_t'(gsat) <<< (WB - pfe_pkg::G_BITS);
	end

	// S2: dot product and clamp to [-1,1]
	logic signed [DW-1:0] dot_c;
	logic signed [DW-1:0] dot_s2;
	logic                 clamped_s2;
	pfe_pkg::mode_t       mode_s2;
	pfe_pkg::q_t          g_s2;

	assign dot_c = DW'(px_s1) + DW'(py_s1) + DW'(pz_s1);

	always_ff @(posedge clk) begin
		if (dot_c > LIM) begin
			dot_s2 <= LIM;
		end else if (dot_c < -LIM) begin
			dot_s2 <= -LIM;
		end else begin
			dot_s2 <= dot_c;
		end
		clamped_s2 <= (dot_c > LIM) || (dot_c < -LIM);
		mode_s2 <= mode_s1;
		g_s2 <= g_s1;
	end

	// S3: cosine in Q.28, rounded half away from zero
	logic [DW-1:0]  dmag;
	logic [DW-1:0]  dscl;
	pfe_pkg::q_t    cq;
	ctx_t           ctx_s3;

	always_comb begin
		dmag = dot_s2[DW-1] ? (~dot_s2 + 1'b1) : dot_s2;
		dscl = ((dmag + RND_IN) >> SHR) << SHL;
		cq = pfe_pkg::q_t'(dscl[QW-1:0]);
	end

	always_ff @(posedge clk) begin
		ctx_s3.mode <= mode_s2;
		ctx_s3.clamped <= clamped_s2;
		ctx_s3.g <= g_s2;
		ctx_s3.c <= dot_s2[DW-1] ? -cq : cq;
	end

	// S4: first products of every mode
	ctx_t        ctx_s4;
	pfe_pkg::q_t cc_s4, h2_s4, gg_s4, gc_s4, gk_s4;
	pfe_pkg::q_t h_c;

	assign h_c = (pfe_pkg::ONE_Q + ctx_s3.c) >>> 1;

	always_ff @(posedge clk) begin
		ctx_s4 <= ctx_s3;
		cc_s4 <= pfe_pkg::fmul(ctx_s3.c, ctx_s3.c);
		h2_s4 <= pfe_pkg::fmul(h_c, h_c);
		gg_s4 <= pfe_pkg::fmul(ctx_s3.g, ctx_s3.g);
		gc_s4 <= pfe_pkg::fmul(ctx_s3.g, ctx_s3.c);
		gk_s4 <= pfe_pkg::fmul(pfe_pkg::K155_Q, ctx_s3.g);
	end

	// S5: Rayleigh value, HG denominator base and numerator, g cubed
	ctx_t        ctx_s5;
	pfe_pkg::q_t ray_s5, h4_s5, d_s5, hgn_s5, ggg_s5, gk_s5;

	always_ff @(posedge clk) begin
		ctx_s5 <= ctx_s4;
		ray_s5 <= pfe_pkg::fmul(pfe_pkg::RAY_Q, pfe_pkg::ONE_Q + cc_s4);
		h4_s5 <= pfe_pkg::fmul(h2_s4, h2_s4);
		d_s5 <= pfe_pkg::ONE_Q + gg_s4 - (gc_s4 <<< 1);
		hgn_s5 <= pfe_pkg::fmul(pfe_pkg::ONE_Q - gg_s4, pfe_pkg::INV4PI_Q);
		ggg_s5 <= pfe_pkg::fmul(gg_s4, ctx_s4.g);
		gk_s5 <= gk_s4;
	end

	// S6: Schlick k
	ctx_t        ctx_s6;
	pfe_pkg::q_t ray_s6, h8_s6, k_s6, d_s6, hgn_s6;

	always_ff @(posedge clk) begin
		ctx_s6 <= ctx_s5;
		ray_s6 <= ray_s5;
		h8_s6 <= pfe_pkg::fmul(h4_s5, h4_s5);
		k_s6 <= gk_s5 - pfe_pkg::fmul(pfe_pkg::K055_Q, ggg_s5);
		d_s6 <= d_s5;
		hgn_s6 <= hgn_s5;
	end

	// S7: k*c and k*k
	ctx_t        ctx_s7;
	pfe_pkg::q_t ray_s7, h8_s7, h16_s7, kc_s7, kk_s7, d_s7, hgn_s7;

	always_ff @(posedge clk) begin
		ctx_s7 <= ctx_s6;
		ray_s7 <= ray_s6;
		h8_s7 <= h8_s6;
		h16_s7 <= pfe_pkg::fmul(h8_s6, h8_s6);
		kc_s7 <= pfe_pkg::fmul(k_s6, ctx_s6.c);
		kk_s7 <= pfe_pkg::fmul(k_s6, k_s6);
		d_s7 <= d_s6;
		hgn_s7 <= hgn_s6;
	end

	// S8: Schlick base and numerator
	ctx_t        ctx_s8;
	pfe_pkg::q_t ray_s8, h8_s8, h32_s8, e_s8, skn_s8, d_s8, hgn_s8;

	always_ff @(posedge clk) begin
		ctx_s8 <= ctx_s7;
		ray_s8 <= ray_s7;
		h8_s8 <= h8_s7;
		h32_s8 <= pfe_pkg::fmul(h16_s7, h16_s7);
		e_s8 <= pfe_pkg::ONE_Q - kc_s7;
		skn_s8 <= pfe_pkg::fmul(pfe_pkg::ONE_Q - kk_s7, pfe_pkg::INV4PI_Q);
		d_s8 <= d_s7;
		hgn_s8 <= hgn_s7;
	end

	// S9: Mie lobe term and Schlick denominator
	ctx_t        ctx_s9;
	pfe_pkg::q_t ray_s9, mm_s9, sden_s9, d_s9, hgn_s9, skn_s9;
	logic        hazy_c;

	assign hazy_c = (ctx_s8.mode == pfe_pkg::MODE_HAZY);

	always_ff @(posedge clk) begin
		ctx_s9 <= ctx_s8;
		ray_s9 <= ray_s8;
		mm_s9 <= pfe_pkg::fmul(hazy_c ? pfe_pkg::MIE_HAZY_Q : pfe_pkg::MIE_MURKY_Q,
			hazy_c ? h8_s8 : h32_s8);
		sden_s9 <= pfe_pkg::fmul(e_s8, e_s8);
		d_s9 <= d_s8;
		hgn_s9 <= hgn_s8;
		skn_s9 <= skn_s8;
	end

	// direct values and square root operand
	pfe_pkg::sq_tag_t                   sq_in_tag;
	logic [pfe_pkg::SQ_IN_W-1:0]        sq_rad;

	always_comb begin
		sq_in_tag.mode = ctx_s9.mode;
		sq_in_tag.clamped = ctx_s9.clamped;
		case (ctx_s9.mode)
			pfe_pkg::MODE_ISO: sq_in_tag.v_direct = pfe_pkg::INV4PI_Q;
			pfe_pkg::MODE_RAY: sq_in_tag.v_direct = ray_s9;
			pfe_pkg::MODE_HAZY,
			pfe_pkg::MODE_MURKY: sq_in_tag.v_direct =
				pfe_pkg::fmul(pfe_pkg::HALF_Q + mm_s9, pfe_pkg::INV4PI_Q);
			default: sq_in_tag.v_direct = '0;
		endcase
		sq_in_tag.num = (ctx_s9.mode == pfe_pkg::MODE_HG) ? hgn_s9 : skn_s9;
		sq_in_tag.d = d_s9;
		sq_in_tag.sden = sden_s9;
		sq_rad = (d_s9 > 0) ?
			{d_s9[pfe_pkg::SQ_IN_W-WB-1:0], {WB{1'b0}}} : '0;
	end

	logic                               sq_out_valid;
	logic [pfe_pkg::SQ_ROOT_W-1:0]      sq_root;
	pfe_pkg::sq_tag_t                   sq_out_tag;

	pfe_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s[9]),
		.in_rad    (sq_rad),
		.in_tag    (sq_in_tag),
		.out_valid (sq_out_valid),
		.out_root  (sq_root),
		.out_tag   (sq_out_tag)
	);

	// S39: divisor selection (d^1.5 for HG, e^2 for Schlick)
	logic                vld_s39;
	pfe_pkg::q_t         den_s39;
	pfe_pkg::q_t         num_s39;
	pfe_pkg::mode_t      mode_s39;
	logic                clamped_s39;
	pfe_pkg::q_t         vdir_s39;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s39 <= 1'b0;
		end else begin
			vld_s39 <= sq_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		den_s39 <= (sq_out_tag.mode == pfe_pkg::MODE_HG) ?
			pfe_pkg::fmul(sq_out_tag.d, pfe_pkg::q_t'(sq_root)) : sq_out_tag.sden;
		num_s39 <= sq_out_tag.num;
		mode_s39 <= sq_out_tag.mode;
		clamped_s39 <= sq_out_tag.clamped;
		vdir_s39 <= sq_out_tag.v_direct;
	end

	// dividend = num * 2^28 + den / 2
	pfe_pkg::div_tag_t                  div_in_tag;
	pfe_pkg::q_t                        num_pos;
	logic [pfe_pkg::DIV_N_W-1:0]        dividend;

	always_comb begin
		num_pos = num_s39[QW-1] ? '0 : num_s39;
		dividend = {num_pos[pfe_pkg::DIV_N_W-WB-1:0], {WB{1'b0}}}
			+ pfe_pkg::DIV_N_W'(den_s39[pfe_pkg::DIV_D_W-1:1]);
		div_in_tag.use_div = (mode_s39 == pfe_pkg::MODE_HG) ||
			(mode_s39 == pfe_pkg::MODE_SCHLICK);
		div_in_tag.fail = (den_s39 <= 0);
		div_in_tag.clamped = clamped_s39;
		div_in_tag.v_direct = vdir_s39;
	end

	logic                               div_out_valid;
	logic [pfe_pkg::DIV_N_W-1:0]        quot;
	pfe_pkg::div_tag_t                  div_out_tag;

	pfe_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_s39),
		.in_dividend (dividend),
		.in_divisor  (den_s39[pfe_pkg::DIV_D_W-1:0]),
		.in_tag      (div_in_tag),
		.out_valid   (div_out_valid),
		.out_quot    (quot),
		.out_tag     (div_out_tag)
	);

	// output rounding and saturation
	logic [VW-1:0] uv;
	logic [VW-1:0] res;
	logic          sat;

	always_comb begin
		if (div_out_tag.use_div) begin
			uv = {1'b0, quot};
		end else if (div_out_tag.v_direct[QW-1]) begin
			uv = '0;
		end else begin
			uv = VW'(div_out_tag.v_direct[QW-2:0]);
		end
		res = (uv + RND_OUT) >> OSH;
		sat = (div_out_tag.use_div && div_out_tag.fail) || (res > OUT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		phase_value <= sat ? 24'hFFFFFF : res[23:0];
		cos_clamped <= div_out_tag.clamped;
		value_saturated <= sat;
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for phase_function_evaluator.
// Depends on pfe_pkg and phase_function_evaluator; predicts each phase value in
// 64-bit fixed point and checks every result against the oldest prediction.
module tb_top;

	// phase mode codes with no phase function behind them
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam longint Q_ONE = 64'sd268435456;
	localparam longint G_MAX = 14746;
	localparam int DRAIN_CYCLES = 110;

	typedef logic signed [15:0] comp_t;
	typedef struct {
		logic [23:0] value;
		logic        clamped;
		logic        saturated;
	} phase_res_t;

	logic clk, arst_n, start, busy, cfg_wr_en, done;
	comp_t out_dir_x, out_dir_y, out_dir_z, in_dir_x, in_dir_y, in_dir_z;
	logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pfe_pkg::G_W-1:0] cfg_wr_data;
	logic [23:0] phase_value;
	logic cos_clamped, value_saturated;

	// predictor copy of the configuration
	logic [2:0] cur_mode;
	logic signed [pfe_pkg::G_W-1:0] cur_g;

	phase_res_t expected_phase[$];
	int mismatches, results_seen, items_sent, clamp_seen, cfg_writes;

	phase_function_evaluator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
		.in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
		.done(done), .phase_value(phase_value), .cos_clamped(cos_clamped),
		.value_saturated(value_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- fixed point helpers ----------------
	function automatic longint unsigned abs_q(input longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	// Q.28 product, rounded to nearest, ties away from zero
	function automatic longint mul_q28(input longint a, input longint b);
		longint unsigned m;
		m = (abs_q(a) * abs_q(b) + 64'd134217728) >> 28;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// phase value for one direction pair under the current configuration
	function automatic phase_res_t predict_phase(input comp_t ox, input comp_t oy,
			input comp_t oz, input comp_t ix, input comp_t iy, input comp_t iz);
		phase_res_t res;
		longint c, g, v, h, gg, d, num, den, k, e;
		longint unsigned q, uv, rnd, s;
		bit ok;
		ok = 1'b1;
		v = 0;
		q = 0;
		res.clamped = 1'b0;
		res.saturated = 1'b0;
		// dot product already carries 28 fraction bits
		c = longint'(ox) * ix + longint'(oy) * iy + longint'(oz) * iz;
		if (c > Q_ONE) begin
			c = Q_ONE;
			res.clamped = 1'b1;
		end
		if (c < -Q_ONE) begin
			c = -Q_ONE;
			res.clamped = 1'b1;
		end
		g = cur_g;
		if (g > G_MAX) g = G_MAX;
		if (g < -G_MAX) g = -G_MAX;
		g = g * 16384;
		case (cur_mode)
			pfe_pkg::MODE_ISO: v = 21361415;
			pfe_pkg::MODE_RAY: v = mul_q28(16021061, Q_ONE + mul_q28(c, c));
			pfe_pkg::MODE_HAZY, pfe_pkg::MODE_MURKY: begin
				h = (Q_ONE + c) / 2;
				for (int i = 0; i < (cur_mode == pfe_pkg::MODE_HAZY ? 3 : 5); i++)
					h = mul_q28(h, h);
				h = (cur_mode == pfe_pkg::MODE_HAZY) ? mul_q28(64'sd1207959552, h)
					: mul_q28(64'sd4429185024, h);
				v = mul_q28(Q_ONE / 2 + h, 21361415);
			end
			pfe_pkg::MODE_HG: begin
				gg = mul_q28(g, g);
				d = Q_ONE + gg - 2 * mul_q28(g, c);
				num = mul_q28(Q_ONE - gg, 21361415);
				s = d > 0 ? floor_sqrt(longint'(d) << 28) : 0;
				den = mul_q28(d, longint'(s));
			end
			pfe_pkg::MODE_SCHLICK: begin
				k = mul_q28(64'sd416074957, g)
					- mul_q28(64'sd147639501, mul_q28(mul_q28(g, g), g));
				e = Q_ONE - mul_q28(k, c);
				num = mul_q28(Q_ONE - mul_q28(k, k), 21361415);
				den = mul_q28(e, e);
			end
			default: v = 0;
		endcase
		if (cur_mode == pfe_pkg::MODE_HG || cur_mode == pfe_pkg::MODE_SCHLICK) begin
			if (den <= 0)
				ok = 1'b0;
			else begin
				uv = num < 0 ? 0 : num;
				q = ((uv << 28) + (longint'(den) >> 1)) / longint'(den);
				v = longint'(q);
			end
		end
		if (!ok) begin
			res.value = 24'hFFFFFF;
			res.saturated = 1'b1;
		end else begin
			uv = v < 0 ? 0 : v;
			rnd = (uv + 64'd2048) >> 12;
			if (rnd > 64'hFFFFFF) begin
				rnd = 64'hFFFFFF;
				res.saturated = 1'b1;
			end
			res.value = rnd[23:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	// check results first, then record the transaction accepted at this edge
	always @(posedge clk) begin
		phase_res_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (expected_phase.size() == 0)
				report_mismatch("result with no transaction outstanding");
			else begin
				exp_r = expected_phase.pop_front();
				if (phase_value !== exp_r.value)
					report_mismatch($sformatf("phase_value %0d, expected %0d",
						phase_value, exp_r.value));
				if (cos_clamped !== exp_r.clamped)
					report_mismatch($sformatf("cos_clamped %b, expected %b",
						cos_clamped, exp_r.clamped));
				if (value_saturated !== exp_r.saturated)
					report_mismatch($sformatf("value_saturated %b, expected %b",
						value_saturated, exp_r.saturated));
				if (exp_r.clamped) clamp_seen++;
			end
		end
		if (arst_n && start && !busy) begin
			expected_phase.push_back(predict_phase(out_dir_x, out_dir_y, out_dir_z,
				in_dir_x, in_dir_y, in_dir_z));
			items_sent++;
		end
	end

	// ---------------- stimulus ----------------
	// present one direction pair after a gap and hold it until accepted
	task automatic send_pair(input comp_t ox, oy, oz, ix, iy, iz, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		out_dir_x <= ox; out_dir_y <= oy; out_dir_z <= oz;
		in_dir_x <= ix; in_dir_y <= iy; in_dir_z <= iz;
		do @(posedge clk); while (busy);
	endtask

	// let every transaction come back and the pipeline empty
	task automatic drain_pipeline();
		start <= 1'b0;
		while (expected_phase.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pfe_pkg::CFG_IDX_W-1:0] idx,
			input logic [pfe_pkg::G_W-1:0] data);
		drain_pipeline();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == pfe_pkg::REG_PHASE_MODE)
			cur_mode = data[2:0];
		else
			cur_g = data;
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] mode,
			input logic signed [pfe_pkg::G_W-1:0] g);
		write_reg(pfe_pkg::REG_PHASE_MODE, pfe_pkg::G_W'(mode));
		write_reg(pfe_pkg::REG_ASYM_G, g);
	endtask

	function automatic comp_t to_comp(input real r);
		return comp_t'(int'(r * 16384.0));
	endfunction

	// mostly unit direction pairs, some near-parallel ones, the rest raw noise
	task automatic send_random_pair();
		real zo, to, ro, zi, ti, ri;
		comp_t a[6];
		int kind, gap;
		kind = $urandom_range(0, 9);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		zo = $urandom_range(0, 20000) / 10000.0 - 1.0;
		to = $urandom_range(0, 62831) / 10000.0;
		ro = $sqrt(1.0 - zo * zo);
		zi = $urandom_range(0, 20000) / 10000.0 - 1.0;
		ti = $urandom_range(0, 62831) / 10000.0;
		ri = $sqrt(1.0 - zi * zi);
		a[0] = to_comp(ro * $cos(to)); a[1] = to_comp(ro * $sin(to)); a[2] = to_comp(zo);
		a[3] = to_comp(ri * $cos(ti)); a[4] = to_comp(ri * $sin(ti)); a[5] = to_comp(zi);
		if (kind < 3) begin
			// near-parallel or near-opposite: dot close to the clamp limits
			for (int i = 0; i < 3; i++) begin
				a[i + 3] = a[i] + comp_t'($urandom_range(0, 4)) - 16'sd2;
				if (kind == 1) a[i + 3] = -a[i + 3];
				if (a[i + 3] > 16384) a[i + 3] = 16384;
				if (a[i + 3] < -16384) a[i + 3] = -16384;
			end
		end else if (kind >= 8) begin
			for (int i = 0; i < 6; i++)
				a[i] = comp_t'($urandom_range(0, 32768)) - 16'sd16384;
		end
		send_pair(a[0], a[1], a[2], a[3], a[4], a[5], gap);
	endtask

	// isotropic straight after reset, with extreme and degenerate vectors
	task automatic test_reset_defaults();
		send_pair(16384, 0, 0, 16384, 0, 0, 0);
		send_pair(16384, 0, 0, -16384, 0, 0, 0);
		send_pair(0, 16384, 0, 16384, 0, 0, 1);
		send_pair(16384, 16384, 16384, 16384, 16384, 16384, 0);
		send_pair(-16384, -16384, -16384, 16384, 16384, 16384, 2);
		send_pair(0, 0, 0, 0, 0, 0, 0);
	endtask

	// every mode but isotropic, spare codes included, at the two ends of the cosine range
	task automatic test_each_mode();
		logic [2:0] modes[7];
		modes = '{pfe_pkg::MODE_RAY, pfe_pkg::MODE_HAZY, pfe_pkg::MODE_MURKY,
			pfe_pkg::MODE_HG, pfe_pkg::MODE_SCHLICK, MODE_SPARE6, MODE_SPARE7};
		foreach (modes[m]) begin
			set_config(modes[m], 15'sd8192);
			send_pair(16384, 0, 0, 16384, 0, 0, 0);
			send_pair(16384, 16384, 0, -16384, -16384, 0, 0);
		end
	endtask

	// asymmetry written beyond the limit in both directions
	task automatic test_asymmetry_limits();
		set_config(pfe_pkg::MODE_HG, 15'sd16383);
		send_pair(16384, 0, 0, 16384, 0, 0, 0);
		send_pair(0, 0, 16384, 0, 0, -16384, 0);
		set_config(pfe_pkg::MODE_SCHLICK, -15'sd16384);
		send_pair(16384, 0, 0, -16384, 0, 0, 0);
		send_pair(16384, 0, 0, 16384, 0, 0, 0);
	endtask

	task automatic test_random_phases();
		logic signed [pfe_pkg::G_W-1:0] g;
		for (int p = 0; p < 16; p++) begin
			case (p % 4)
				0: g = 15'sd14746;
				1: g = -15'sd14746;
				2: g = 15'sd0;
				default: g = pfe_pkg::G_W'($urandom_range(0, 32767));
			endcase
			set_config(3'(p % 8), g);
			repeat (33) send_random_pair();
		end
		// one long phase without gaps to exercise full throughput
		set_config(pfe_pkg::MODE_SCHLICK, 15'sd9000);
		repeat (30) send_pair(16384, 0, 0, 16384, 0, 0, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = pfe_pkg::REG_PHASE_MODE;
		cfg_wr_data = '0;
		out_dir_x = 0; out_dir_y = 0; out_dir_z = 0;
		in_dir_x = 0; in_dir_y = 0; in_dir_z = 0;
		cur_mode = pfe_pkg::MODE_ISO;
		cur_g = 0;
		mismatches = 0; results_seen = 0; items_sent = 0; clamp_seen = 0; cfg_writes = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_each_mode();
		test_asymmetry_limits();
		test_random_phases();
		drain_pipeline();
		$display("Run covered %0d transactions, %0d results, %0d with a clamped cosine,",
			items_sent, results_seen, clamp_seen);
		$display("over %0d register writes across all eight mode codes.", cfg_writes);
		if (mismatches == 0 && expected_phase.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("Timeout: run did not complete");
		$display("*** FAILED ***");
		$finish;
	end
endmodule
